/* sv/i2cm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types and constants for the 16-bit register transaction master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [6:0] DEV_ADDR_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_HI = 4'd1,
    PH_START_LO = 4'd2,
    PH_BIT_LO   = 4'd3,
    PH_BIT_HI   = 4'd4,
    PH_ACK_LO   = 4'd5,
    PH_ACK_HI   = 4'd6,
    PH_STRETCH  = 4'd7,
    PH_RD_LO    = 4'd8,
    PH_RD_HI    = 4'd9,
    PH_MACK_LO  = 4'd10,
    PH_MACK_HI  = 4'd11,
    PH_STOP_LO  = 4'd12,
    PH_STOP_MID = 4'd13,
    PH_STOP_HI  = 4'd14,
    PH_RS_LO    = 4'd15
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  register_address;
    logic [15:0] write_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_enable;
    logic        busy_res;
    logic        read_valid;
    logic [15:0] read_word;
    logic        nack_seen;
  } out_item_t;

endpackage

/* sv/i2cm_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master phase sequencer
// Holds the transaction state and works out one tick's bus levels per beat.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  i2cm_pkg::in_item_t  item,
  input  logic [6:0]          dev_addr,
  output i2cm_pkg::out_item_t result
);
  import i2cm_pkg::*;

  kind_t       kind_r, kind_nxt, cur_kind;
  phase_t      phase_r, phase_nxt, cur_phase, after_phase;
  logic [3:0]  bit_r, bit_nxt, cur_bit, after_bit, bit_inc;
  logic [2:0]  byte_r, byte_nxt, cur_byte, after_byte, byte_inc;
  logic [7:0]  shift_r, shift_nxt, cur_shift, after_shift, first_byte, next_byte;
  logic [15:0] word_r, word_nxt, cur_word;
  logic [7:0]  reg_r, reg_nxt, cur_reg;
  logic        nack_r, nack_nxt, cur_nack;
  logic        begin_hit;

  function automatic logic [7:0] byte_to_send(input logic [6:0]  addr,
                                              input logic [2:0]  idx,
                                              input kind_t       kind,
                                              input logic [7:0]  regb,
                                              input logic [15:0] word);
    logic [7:0] res;
    unique case (idx)
      3'd0: res = {addr, 1'b0};
      3'd1: res = regb;
      3'd2: res = (kind == KIND_READ) ? {addr, 1'b1} : word[15:8];
      3'd3: res = word[7:0];
      default: res = 8'hFF;
    endcase
    return res;
  endfunction

  always_comb begin
    begin_hit = (phase_r == PH_IDLE) &&
                (item.operation == OP_WRITE || item.operation == OP_READ);
    cur_kind  = kind_r;
    cur_phase = phase_r;
    cur_bit   = bit_r;
    cur_byte  = byte_r;
    cur_shift = shift_r;
    cur_word  = word_r;
    cur_reg   = reg_r;
    cur_nack  = nack_r;
    if (begin_hit) begin
      cur_kind  = (item.operation == OP_WRITE) ? KIND_WRITE : KIND_READ;
      cur_phase = PH_START_HI;
      cur_bit   = '0;
      cur_byte  = '0;
      cur_shift = '0;
      cur_word  = (item.operation == OP_WRITE) ? item.write_data : '0;
      cur_reg   = item.register_address;
      cur_nack  = 1'b0;
    end
  end

  assign bit_inc    = cur_bit + 4'd1;
  assign byte_inc   = cur_byte + 3'd1;
  assign first_byte = byte_to_send(dev_addr, cur_byte, cur_kind, cur_reg, cur_word);
  assign next_byte  = byte_to_send(dev_addr, byte_inc, cur_kind, cur_reg, cur_word);

  // Continuation once a sent byte's acknowledge slot is over.
  always_comb begin
    after_byte  = byte_inc;
    after_shift = cur_shift;
    after_bit   = cur_bit;
    after_phase = PH_STOP_LO;
    if (cur_kind == KIND_READ) begin
      if (byte_inc == 3'd2) begin
        after_phase = PH_RS_LO;
      end else if (byte_inc == 3'd3) begin
        after_shift = '0;
        after_bit   = '0;
        after_phase = PH_RD_LO;
      end
    end else if (byte_inc < 3'd4) begin
      after_shift = next_byte;
      after_bit   = '0;
      after_phase = PH_BIT_LO;
    end
  end

  always_comb begin
    kind_nxt  = cur_kind;
    phase_nxt = cur_phase;
    bit_nxt   = cur_bit;
    byte_nxt  = cur_byte;
    shift_nxt = cur_shift;
    word_nxt  = cur_word;
    reg_nxt   = cur_reg;
    nack_nxt  = cur_nack;
    unique case (cur_phase)
      PH_IDLE: ;
      PH_START_HI: phase_nxt = PH_START_LO;
      PH_START_LO: begin
        shift_nxt = first_byte;
        bit_nxt   = '0;
        phase_nxt = PH_BIT_LO;
      end
      PH_BIT_LO: phase_nxt = PH_BIT_HI;
      PH_BIT_HI: begin
        shift_nxt = {cur_shift[6:0], 1'b0};
        bit_nxt   = bit_inc;
        phase_nxt = bit_inc[3] ? PH_ACK_LO : PH_BIT_LO;
      end
      PH_ACK_LO: phase_nxt = PH_ACK_HI;
      PH_ACK_HI: begin
        if (item.sda_in) begin
          nack_nxt  = 1'b1;
          phase_nxt = PH_STRETCH;
        end else begin
          byte_nxt  = after_byte;
          shift_nxt = after_shift;
          bit_nxt   = after_bit;
          phase_nxt = after_phase;
        end
      end
      PH_STRETCH: begin
        byte_nxt  = after_byte;
        shift_nxt = after_shift;
        bit_nxt   = after_bit;
        phase_nxt = after_phase;
      end
      PH_RD_LO: phase_nxt = PH_RD_HI;
      PH_RD_HI: begin
        shift_nxt = {cur_shift[6:0], item.sda_in};
        bit_nxt   = bit_inc;
        phase_nxt = bit_inc[3] ? PH_MACK_LO : PH_RD_LO;
      end
      PH_MACK_LO: phase_nxt = PH_MACK_HI;
      PH_MACK_HI: begin
        word_nxt = {cur_word[7:0], cur_shift};
        byte_nxt = byte_inc;
        if (byte_inc == 3'd4) begin
          shift_nxt = '0;
          bit_nxt   = '0;
          phase_nxt = PH_RD_LO;
        end else begin
          phase_nxt = PH_STOP_LO;
        end
      end
      PH_STOP_LO:  phase_nxt = PH_STOP_MID;
      PH_STOP_MID: phase_nxt = PH_STOP_HI;
      PH_STOP_HI: begin
        kind_nxt  = KIND_IDLE;
        phase_nxt = PH_IDLE;
      end
      PH_RS_LO: phase_nxt = PH_START_HI;
    endcase
  end

  always_comb begin
    result            = '0;
    result.scl_level  = 1'b1;
    result.sda_level  = 1'b1;
    result.sda_enable = 1'b1;
    result.busy_res   = 1'b1;
    result.nack_seen  = nack_nxt;
    unique case (cur_phase)
      PH_IDLE:     result.busy_res = 1'b0;
      PH_START_HI: ;
      PH_START_LO: result.sda_level = 1'b0;
      PH_BIT_LO: begin
        result.scl_level = 1'b0;
        result.sda_level = cur_shift[7];
      end
      PH_BIT_HI:   result.sda_level = cur_shift[7];
      PH_ACK_LO: begin
        result.scl_level  = 1'b0;
        result.sda_enable = 1'b0;
      end
      PH_ACK_HI, PH_STRETCH, PH_RD_HI: result.sda_enable = 1'b0;
      PH_RD_LO: begin
        result.scl_level  = 1'b0;
        result.sda_enable = 1'b0;
      end
      PH_MACK_LO: begin
        result.scl_level = 1'b0;
        result.sda_level = cur_byte[2];
      end
      PH_MACK_HI:  result.sda_level = cur_byte[2];
      PH_STOP_LO: begin
        result.scl_level = 1'b0;
        result.sda_level = 1'b0;
      end
      PH_STOP_MID: result.sda_level = 1'b0;
      PH_STOP_HI: begin
        if (cur_kind == KIND_READ) begin
          result.read_valid = 1'b1;
          result.read_word  = cur_word;
        end
      end
      PH_RS_LO:    result.scl_level = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_IDLE;
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      byte_r  <= '0;
      shift_r <= '0;
      word_r  <= '0;
      reg_r   <= '0;
      nack_r  <= 1'b0;
    end else if (advance) begin
      kind_r  <= kind_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      shift_r <= shift_nxt;
      word_r  <= word_nxt;
      reg_r   <= reg_nxt;
      nack_r  <= nack_nxt;
    end
  end

endmodule

/* sv/i2c_master_register_access_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access unit
// Tick-driven I2C master for 16-bit register writes and reads.
// ----------------------------------------------------------------------------
// A beat waits in the input register; the sequencer's result for it is
// registered in the result register. Throughput: one beat per cycle while
// the receiver takes results; each register takes a new beat as its own moves on.
// Reset: synchronous, active low; the bus sequencer returns to idle, both
// registers empty and the device address returns to 64.
module i2c_master_register_access_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import i2cm_pkg::*;

  in_item_t   in_data_r;
  logic       in_valid_r;
  out_item_t  out_data_r;
  logic       out_valid_r;
  out_item_t  result;
  logic [6:0] dev_addr_r;
  logic       advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  i2cm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (in_data_r),
    .dev_addr (dev_addr_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input register empty but not ready");

  a_read_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.read_valid |-> out_data_r.busy_res)
    else $error("read word delivered outside a transaction");

  a_word_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.read_valid |-> out_data_r.read_word == 16'd0)
    else $error("read word not zero without a completed read");

  a_released_sda_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.sda_enable |-> out_data_r.sda_level)
    else $error("SDA released with a low level");

  a_idle_bus_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.busy_res |->
      out_data_r.scl_level && out_data_r.sda_level && out_data_r.sda_enable)
    else $error("idle beat does not drive both lines high");

endmodule

/* test/i2c_bus_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access checker
// Watches the tick, result and address channels of the register access unit.
// It models the bus sequencer tick by tick, queues the bus levels expected
// for each accepted tick and compares every result beat with the oldest one.
// ----------------------------------------------------------------------------
module i2c_bus_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  i2cm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  i2cm_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [6:0]          cfg_data,
  output int                  fault_count,
  output int                  ticks_pending
);
  import i2cm_pkg::*;

  logic [6:0]  dev_addr;
  kind_t       bus_kind;
  phase_t      bus_phase;
  logic [3:0]  bit_count;
  logic [2:0]  byte_count;
  logic [7:0]  shift_reg;
  logic [15:0] word_reg;
  logic [7:0]  reg_ptr;
  logic        nack_flag;

  out_item_t   expected_bus_q[$];

  task automatic reset_bus_model();
    dev_addr   = DEV_ADDR_RESET;
    bus_kind   = KIND_IDLE;
    bus_phase  = PH_IDLE;
    bit_count  = '0;
    byte_count = '0;
    shift_reg  = '0;
    word_reg   = '0;
    reg_ptr    = '0;
    nack_flag  = 1'b0;
  endtask

  function automatic logic [7:0] next_tx_byte();
    case (byte_count)
      3'd0: return {dev_addr, 1'b0};
      3'd1: return reg_ptr;
      3'd2: return (bus_kind == KIND_READ) ? {dev_addr, 1'b1} : word_reg[15:8];
      3'd3: return word_reg[7:0];
      default: return 8'hFF;
    endcase
  endfunction

  task automatic load_tx_byte();
    shift_reg = next_tx_byte();
    bit_count = '0;
    bus_phase = PH_BIT_LO;
  endtask

  // Decides what follows the acknowledge slot of a byte sent by the master.
  task automatic finish_tx_byte();
    byte_count = byte_count + 3'd1;
    if (bus_kind == KIND_READ) begin
      if (byte_count == 3'd2) begin
        bus_phase = PH_RS_LO;
      end else if (byte_count == 3'd3) begin
        shift_reg = '0;
        bit_count = '0;
        bus_phase = PH_RD_LO;
      end else begin
        bus_phase = PH_STOP_LO;
      end
    end else if (byte_count < 3'd4) begin
      load_tx_byte();
    end else begin
      bus_phase = PH_STOP_LO;
    end
  endtask

  task automatic step_bus(input in_item_t tick, output out_item_t res);
    logic master_nack;
    res = '0;
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;
    res.sda_enable = 1'b1;
    res.busy_res   = 1'b1;

    if (bus_phase == PH_IDLE &&
        (tick.operation == OP_WRITE || tick.operation == OP_READ)) begin
      bus_kind   = (tick.operation == OP_WRITE) ? KIND_WRITE : KIND_READ;
      reg_ptr    = tick.register_address;
      word_reg   = (tick.operation == OP_WRITE) ? tick.write_data : 16'h0000;
      nack_flag  = 1'b0;
      byte_count = '0;
      bit_count  = '0;
      shift_reg  = '0;
      bus_phase  = PH_START_HI;
    end

    master_nack = (byte_count >= 3'd4);
    case (bus_phase)
      PH_IDLE: begin
        res.busy_res = 1'b0;
      end
      PH_START_HI: begin
        bus_phase = PH_START_LO;
      end
      PH_START_LO: begin
        res.sda_level = 1'b0;
        load_tx_byte();
      end
      PH_BIT_LO: begin
        res.scl_level = 1'b0;
        res.sda_level = shift_reg[7];
        bus_phase = PH_BIT_HI;
      end
      PH_BIT_HI: begin
        res.sda_level = shift_reg[7];
        shift_reg = shift_reg << 1;
        bit_count = bit_count + 4'd1;
        bus_phase = (bit_count >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
      end
      PH_ACK_LO: begin
        res.scl_level  = 1'b0;
        res.sda_enable = 1'b0;
        bus_phase = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        res.sda_enable = 1'b0;
        if (tick.sda_in) begin
          nack_flag = 1'b1;
          bus_phase = PH_STRETCH;
        end else begin
          finish_tx_byte();
        end
      end
      PH_STRETCH: begin
        res.sda_enable = 1'b0;
        finish_tx_byte();
      end
      PH_RD_LO: begin
        res.scl_level  = 1'b0;
        res.sda_enable = 1'b0;
        bus_phase = PH_RD_HI;
      end
      PH_RD_HI: begin
        res.sda_enable = 1'b0;
        shift_reg = {shift_reg[6:0], tick.sda_in};
        bit_count = bit_count + 4'd1;
        bus_phase = (bit_count >= 4'd8) ? PH_MACK_LO : PH_RD_LO;
      end
      PH_MACK_LO: begin
        res.scl_level = 1'b0;
        res.sda_level = master_nack;
        bus_phase = PH_MACK_HI;
      end
      PH_MACK_HI: begin
        res.sda_level = master_nack;
        word_reg = {word_reg[7:0], shift_reg};
        byte_count = byte_count + 3'd1;
        if (byte_count == 3'd4) begin
          shift_reg = '0;
          bit_count = '0;
          bus_phase = PH_RD_LO;
        end else begin
          bus_phase = PH_STOP_LO;
        end
      end
      PH_STOP_LO: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
        bus_phase = PH_STOP_MID;
      end
      PH_STOP_MID: begin
        res.sda_level = 1'b0;
        bus_phase = PH_STOP_HI;
      end
      PH_STOP_HI: begin
        if (bus_kind == KIND_READ) begin
          res.read_valid = 1'b1;
          res.read_word  = word_reg;
        end
        bus_kind  = KIND_IDLE;
        bus_phase = PH_IDLE;
      end
      default: begin
        res.scl_level = 1'b0;
        bus_phase = PH_START_HI;
      end
    endcase
    res.nack_seen = nack_flag;
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      reset_bus_model();
      expected_bus_q.delete();
      fault_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) dev_addr = cfg_data;
      if (in_valid && in_ready) begin
        step_bus(in_data, want);
        expected_bus_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_bus_q.size() == 0) begin
          $display("%0t ns: result beat with none expected, got %0h", $time, out_data);
          fault_count++;
        end else begin
          want = expected_bus_q.pop_front();
          report_field("scl_level", want.scl_level, out_data.scl_level);
          report_field("sda_level", want.sda_level, out_data.sda_level);
          report_field("sda_enable", want.sda_enable, out_data.sda_enable);
          report_field("busy_res", want.busy_res, out_data.busy_res);
          report_field("read_valid", want.read_valid, out_data.read_valid);
          report_field("read_word", want.read_word, out_data.read_word);
          report_field("nack_seen", want.nack_seen, out_data.nack_seen);
        end
      end
    end
    ticks_pending = expected_bus_q.size();
  end

endmodule

/* test/tb_i2c_master_register_access_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the I2C master register access unit
// Drives half-bit ticks carrying register writes and reads, with the target's
// SDA answers, through bursty input beats and a stalling result receiver.
// The device address is changed between phases; the checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access_unit;
  import i2cm_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;

  typedef enum int {SDA_ACK, SDA_NACK, SDA_MIXED} sda_mode_t;
  typedef enum int {RX_FREE, RX_ALTERNATE, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  int          fault_count;
  int          ticks_pending;
  int          burst_left = 0;
  int unsigned beats_sent = 0;
  int          idle_cycles = 0;
  rx_mode_t    rx_mode = RX_FREE;
  int          rx_window = 0;
  logic [7:0]  rx_count = '0;

  i2c_master_register_access_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  i2c_bus_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fault_count   (fault_count),
    .ticks_pending (ticks_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rx_window == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      rx_window <= $urandom_range(20, 120);
    end else begin
      rx_window <= rx_window - 1;
    end
    case (rx_mode)
      RX_FREE:      out_ready <= 1'b1;
      RX_ALTERNATE: out_ready <= rx_count[0];
      RX_RANDOM:    out_ready <= ($urandom_range(0, 3) != 0);
      default:      out_ready <= (rx_count[4:0] < 5'd6);
    endcase
    rx_count <= rx_count + 8'd1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic pick_sda(input sda_mode_t mode);
    case (mode)
      SDA_ACK:  return 1'b0;
      SDA_NACK: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input in_item_t tick);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_data  <= tick;
    in_valid <= 1'b1;
    burst_left--;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic run_transfer(input logic [1:0] op, input logic [7:0] reg_ptr,
                              input logic [15:0] word, input sda_mode_t mode,
                              input int tail, input bit noisy);
    in_item_t tick;
    int n;
    tick.operation        = op;
    tick.register_address = reg_ptr;
    tick.write_data       = word;
    tick.sda_in           = pick_sda(mode);
    send_beat(tick);
    for (n = 0; n < tail; n++) begin
      tick.operation = OP_TICK;
      if (noisy && $urandom_range(0, 19) == 0) tick.operation = 2'($urandom_range(0, 3));
      tick.register_address = 8'($urandom);
      tick.write_data       = 16'($urandom);
      tick.sda_in           = pick_sda(mode);
      send_beat(tick);
    end
  endtask

  task automatic settle_bus();
    in_valid <= 1'b0;
    while (ticks_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_address(input logic [6:0] addr);
    cfg_data  <= addr;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(input int unsigned beats);
    int unsigned first;
    int pick;
    logic [1:0] op;
    int tail;
    first = beats_sent;
    while (beats_sent - first < beats) begin
      pick = $urandom_range(0, 9);
      op   = (pick < 5) ? OP_WRITE : ((pick < 9) ? OP_READ : OP_UNUSED);
      tail = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 80) : $urandom_range(85, 115);
      run_transfer(op, 8'($urandom), 16'($urandom), sda_mode_t'($urandom_range(0, 2)),
                   tail, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_transfer(OP_UNUSED, 8'hFF, 16'hFFFF, SDA_NACK, 2, 1'b0);
    run_transfer(OP_WRITE, 8'hFF, 16'hFFFF, SDA_ACK, 80, 1'b0);
    settle_bus();

    write_address(7'd0);
    run_transfer(OP_READ, 8'hFF, 16'hFFFF, SDA_NACK, 105, 1'b0);
    run_transfer(OP_READ, 8'hA5, 16'h5A5A, SDA_MIXED, 30, 1'b0);
    run_transfer(OP_WRITE, 8'h3C, 16'hC33C, SDA_MIXED, 90, 1'b0);
    settle_bus();

    write_address(7'd127);
    random_phase(300);
    settle_bus();

    if (fault_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/i2cm_pkg.sv
sv/i2cm_seq.sv
sv/i2c_master_register_access_unit.sv
test/i2c_bus_checker.sv
test/tb_i2c_master_register_access_unit.sv
